### hw/rtl/u2u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 converter.
package u2u8_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [11:0] POS_MAX = 12'hFFF;
  localparam logic [5:0] HIGH_SUR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SUR_TAG = 6'b110111;
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [15:0] REPLACEMENT = 16'hFFFD;

  typedef struct packed {
    logic        cp0_valid;
    logic [20:0] cp0;
    logic        cp1_valid;
    logic [15:0] cp1;
    logic        marker;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

### hw/rtl/u2u8_front.sv
// Front part: accepts code units, tracks surrogates and limits, issues encode commands.
module u2u8_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [23:0]            s_tdata,  // code_unit [15:0], char_limit [23:16]
  input  logic                   s_tlast,
  input  logic [0:0]             s_tuser,  // first_unit [0]
  input  u2u8_pkg::queue_status_t q_status,
  output logic                   q_push,
  output u2u8_pkg::cmd_t         q_cmd
);

  logic [9:0]  held_high;
  logic        held_valid;
  logic [11:0] unit_position;
  logic [7:0]  unit_limit;
  logic        stopped;

  logic [9:0]  held_high_next;
  logic        held_valid_next;
  logic [11:0] unit_position_next;
  logic        stopped_next;

  logic        accept;
  logic        first;
  logic [15:0] unit;
  logic [11:0] pos_c;
  logic [7:0]  limit_c;
  logic        stop_c;
  logic        held_c;
  logic        is_low;
  logic        is_high;
  logic        consumed;
  logic        active;
  logic        hold;

  assign s_tready = !q_status.full;
  assign accept = s_tvalid && s_tready;
  assign first = s_tuser[0];
  assign unit = s_tdata[15:0];

  always_comb begin
    pos_c = first ? 12'd0 : unit_position;
    limit_c = first ? s_tdata[23:16] : unit_limit;
    stop_c = first ? 1'b0 : stopped;
    held_c = first ? 1'b0 : held_valid;
    is_low = (unit[15:10] == u2u8_pkg::LOW_SUR_TAG);
    is_high = (unit[15:10] == u2u8_pkg::HIGH_SUR_TAG);
    consumed = held_c && is_low;
    active = !consumed && !stop_c && (pos_c < {4'd0, limit_c});
    hold = active && is_high && !s_tlast;

    q_cmd.cp0_valid = held_c;
    q_cmd.cp0 = is_low ? (u2u8_pkg::SUPP_BASE + {1'b0, held_high, unit[9:0]})
                       : {5'd0, u2u8_pkg::REPLACEMENT};
    q_cmd.cp1_valid = active && (unit != 16'd0) && !hold;
    q_cmd.cp1 = (is_high || is_low) ? u2u8_pkg::REPLACEMENT : unit;
    q_cmd.marker = s_tlast;

    q_push = accept && (q_cmd.cp0_valid || q_cmd.cp1_valid || q_cmd.marker);

    unit_position_next = (pos_c == u2u8_pkg::POS_MAX) ? pos_c : pos_c + 12'd1;
    held_valid_next = hold;
    held_high_next = hold ? unit[9:0] : 10'd0;
    stopped_next = stop_c || (active && (unit == 16'd0)) || s_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_high <= 10'd0;
      held_valid <= 1'b0;
      unit_position <= 12'd0;
      unit_limit <= 8'd0;
      stopped <= 1'b0;
    end else if (accept) begin
      held_high <= held_high_next;
      held_valid <= held_valid_next;
      unit_position <= unit_position_next;
      unit_limit <= limit_c;
      stopped <= stopped_next;
    end
  end

`ifndef ASSERT_OFF
  a_held_not_stopped: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> !stopped)
    else $error("held surrogate while the name is stopped");

  a_held_clear: assert property (@(posedge clk) disable iff (rst)
    !held_valid |-> (held_high == 10'd0))
    else $error("held surrogate bits without a held unit");
`endif

endmodule

### hw/rtl/u2u8_queue.sv
// Short command queue between the front and back parts.
module u2u8_queue #(
  parameter int unsigned Depth = u2u8_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  u2u8_pkg::cmd_t          push_cmd,
  input  logic                    pop,
  output u2u8_pkg::cmd_t          head_cmd,
  output u2u8_pkg::queue_status_t status
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  u2u8_pkg::cmd_t entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic do_push;
  logic do_pop;

  assign status.full = (count == CntFull);
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop = pop && !status.empty;
  assign head_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full)
    else $error("command pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntFull)
    else $error("queue count beyond depth");
`endif

endmodule

### hw/rtl/u2u8_back.sv
// Back part: expands commands into UTF-8 bytes and the end marker, one per cycle while the output slot is free.
module u2u8_back (
  input  logic                    clk,
  input  logic                    rst,
  input  u2u8_pkg::queue_status_t q_status,
  input  u2u8_pkg::cmd_t          head_cmd,
  output logic                    q_pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [7:0]              m_tdata,  // out_byte [7:0]
  output logic                    m_tlast,
  output logic [1:0]              m_tuser   // byte_valid [0], end_of_name [1]
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CP0  = 4'b0010,
    ST_CP1  = 4'b0100,
    ST_MARK = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  state_t load_state;
  u2u8_pkg::cmd_t cmd;
  logic [1:0] idx;
  logic [1:0] idx_next;

  logic [20:0] cur_cp;
  logic [1:0]  len_m1;
  logic [1:0]  remain;
  logic [7:0]  cur_byte;
  logic        byte_last;
  logic        slot_free;
  logic        emit;
  logic        done;
  logic        load;

  always_comb begin
    cur_cp = (state == ST_CP1) ? {5'd0, cmd.cp1} : cmd.cp0;
    if (cur_cp < 21'h80) begin
      len_m1 = 2'd0;
    end else if (cur_cp < 21'h800) begin
      len_m1 = 2'd1;
    end else if (cur_cp < 21'h10000) begin
      len_m1 = 2'd2;
    end else begin
      len_m1 = 2'd3;
    end
    remain = len_m1 - idx;
    byte_last = (remain == 2'd0);
    if (idx == 2'd0) begin
      unique case (len_m1)
        2'd0: cur_byte = cur_cp[7:0];
        2'd1: cur_byte = {3'b110, cur_cp[10:6]};
        2'd2: cur_byte = {4'b1110, cur_cp[15:12]};
        default: cur_byte = {5'b11110, cur_cp[20:18]};
      endcase
    end else begin
      unique case (remain)
        2'd0: cur_byte = {2'b10, cur_cp[5:0]};
        2'd1: cur_byte = {2'b10, cur_cp[11:6]};
        default: cur_byte = {2'b10, cur_cp[17:12]};
      endcase
    end
  end

  assign slot_free = !m_tvalid || m_tready;
  assign emit = (state != ST_IDLE) && slot_free;

  always_comb begin
    state_next = state;
    idx_next = idx;
    done = 1'b0;
    unique case (state)
      ST_CP0: begin
        if (byte_last) begin
          idx_next = 2'd0;
          if (cmd.cp1_valid) begin
            state_next = ST_CP1;
          end else if (cmd.marker) begin
            state_next = ST_MARK;
          end else begin
            done = 1'b1;
          end
        end else begin
          idx_next = idx + 2'd1;
        end
      end
      ST_CP1: begin
        if (byte_last) begin
          idx_next = 2'd0;
          if (cmd.marker) begin
            state_next = ST_MARK;
          end else begin
            done = 1'b1;
          end
        end else begin
          idx_next = idx + 2'd1;
        end
      end
      ST_MARK: begin
        done = 1'b1;
      end
      default: begin
        done = 1'b0;
      end
    endcase
    if (done) begin
      state_next = ST_IDLE;
    end
  end

  always_comb begin
    if (head_cmd.cp0_valid) begin
      load_state = ST_CP0;
    end else if (head_cmd.cp1_valid) begin
      load_state = ST_CP1;
    end else begin
      load_state = ST_MARK;
    end
  end

  assign load = !q_status.empty && ((state == ST_IDLE) || (emit && done));
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx <= 2'd0;
    end else if (load) begin
      state <= load_state;
      idx <= 2'd0;
    end else if (emit) begin
      state <= state_next;
      idx <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd <= head_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= (state == ST_MARK) ? 8'd0 : cur_byte;
      m_tlast <= done;
      m_tuser <= {state == ST_MARK, state != ST_MARK};
    end
  end

`ifndef ASSERT_OFF
  a_marker_closes: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tlast && !m_tuser[0]))
    else $error("end marker not closing its request");

  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (idx == 2'd0))
    else $error("byte index left over in idle");
`endif

endmodule

### hw/rtl/utf16_to_utf8_converter.sv
// Top level of the UTF-16 to UTF-8 converter: front, command queue and back.
//
// Channel | Direction | tdata                          | tlast     | tuser
// s_*     | in        | code_unit[15:0], char_limit[23:16] | last_unit | first_unit[0]
// m_*     | out       | out_byte[7:0]                  | run_last  | byte_valid[0], end_of_name[1]
//
// The front takes one code unit request per cycle while the command queue has room.
// The back sends one result per cycle while the output accepts them, so the single output
// port sets the sustained rate.
// A request that causes no result pushes no command into the queue.
// Synchronous reset empties the queue and clears surrogate, position and limit state.
// A stalled output backs up into the queue of QueueDepth commands, then stalls the input.
module utf16_to_utf8_converter #(
  parameter int unsigned QueueDepth = u2u8_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // code_unit [15:0], char_limit [23:16]
  input  logic        s_tlast,
  input  logic [0:0]  s_tuser,  // first_unit [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // out_byte [7:0]
  output logic        m_tlast,
  output logic [1:0]  m_tuser   // byte_valid [0], end_of_name [1]
);

  u2u8_pkg::queue_status_t q_status;
  u2u8_pkg::cmd_t          push_cmd;
  u2u8_pkg::cmd_t          head_cmd;
  logic                    q_push;
  logic                    q_pop;

  u2u8_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .q_status (q_status),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  u2u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  u2u8_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .head_cmd (head_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

### test/utf8_stream_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the UTF-8 result stream from accepted code units and compares it.
module utf8_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,  // code_unit [15:0], char_limit [23:16]
  input  logic        s_tlast,
  input  logic [0:0]  s_tuser,  // first_unit [0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,  // out_byte [7:0]
  input  logic        m_tlast,
  input  logic [1:0]  m_tuser,  // byte_valid [0], end_of_name [1]
  output int          mismatch_count,
  output int          pending_bytes
);

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       run_end;
    logic       name_end;
  } utf8_result_t;

  utf8_result_t utf8_expected[$];

  logic [9:0]  held_high;
  logic        held_valid;
  logic [11:0] unit_pos;
  logic [7:0]  unit_lim;
  logic        stopped;

  task automatic add_result(input logic [7:0] data, input logic valid, input logic name_end);
    utf8_expected.insert(utf8_expected.size(), {data, valid, 1'b0, name_end});
  endtask

  task automatic encode_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_result(cp[7:0], 1'b1, 1'b0);
    end else if (cp < 21'h800) begin
      add_result({3'b110, cp[10:6]}, 1'b1, 1'b0);
      add_result({2'b10, cp[5:0]}, 1'b1, 1'b0);
    end else if (cp < u2u8_pkg::SUPP_BASE) begin
      add_result({4'b1110, cp[15:12]}, 1'b1, 1'b0);
      add_result({2'b10, cp[11:6]}, 1'b1, 1'b0);
      add_result({2'b10, cp[5:0]}, 1'b1, 1'b0);
    end else begin
      add_result({5'b11110, cp[20:18]}, 1'b1, 1'b0);
      add_result({2'b10, cp[17:12]}, 1'b1, 1'b0);
      add_result({2'b10, cp[11:6]}, 1'b1, 1'b0);
      add_result({2'b10, cp[5:0]}, 1'b1, 1'b0);
    end
  endtask

  // Works out the bytes that one code unit request causes and queues them.
  task automatic predict_utf8(input logic [15:0] unit, input logic first, input logic last,
                              input logic [7:0] limit);
    logic [11:0] pos;
    logic        is_low;
    logic        is_high;
    logic        consumed;
    int          start;
    start = utf8_expected.size();
    is_low = unit[15:10] == u2u8_pkg::LOW_SUR_TAG;
    is_high = unit[15:10] == u2u8_pkg::HIGH_SUR_TAG;
    consumed = 1'b0;
    if (first) begin
      held_high = '0;
      held_valid = 1'b0;
      unit_pos = '0;
      unit_lim = limit;
      stopped = 1'b0;
    end
    pos = unit_pos;
    if (unit_pos != u2u8_pkg::POS_MAX) unit_pos = unit_pos + 12'd1;
    if (held_valid) begin
      held_valid = 1'b0;
      if (is_low) begin
        encode_point(u2u8_pkg::SUPP_BASE + {1'b0, held_high, unit[9:0]});
        consumed = 1'b1;
      end else begin
        encode_point({5'd0, u2u8_pkg::REPLACEMENT});
      end
      held_high = '0;
    end
    if (!consumed && !stopped && pos < {4'd0, unit_lim}) begin
      if (unit == 16'h0000) begin
        stopped = 1'b1;
      end else if (is_high) begin
        if (last) begin
          encode_point({5'd0, u2u8_pkg::REPLACEMENT});
        end else begin
          held_high = unit[9:0];
          held_valid = 1'b1;
        end
      end else if (is_low) begin
        encode_point({5'd0, u2u8_pkg::REPLACEMENT});
      end else begin
        encode_point({5'd0, unit});
      end
    end
    if (last) begin
      add_result(8'h00, 1'b0, 1'b1);
      stopped = 1'b1;
      held_valid = 1'b0;
      held_high = '0;
    end
    if (utf8_expected.size() > start) utf8_expected[utf8_expected.size() - 1].run_end = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input utf8_result_t want,
                                 input utf8_result_t got);
    if (mismatch_count < 10) begin
      $write("%0t: %s: expected byte=%02h valid=%b run_last=%b end=%b, ",
             $realtime, what, want.data, want.valid, want.run_end, want.name_end);
      $display("got byte=%02h valid=%b run_last=%b end=%b",
               got.data, got.valid, got.run_end, got.name_end);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    utf8_result_t got;
    utf8_result_t want;
    if (rst) begin
      utf8_expected.delete();
      held_high = '0;
      held_valid = 1'b0;
      unit_pos = '0;
      unit_lim = '0;
      stopped = 1'b0;
      mismatch_count = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_utf8(s_tdata[15:0], s_tuser[0], s_tlast, s_tdata[23:16]);
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
        if (utf8_expected.size() == 0) begin
          report_mismatch("result with nothing expected", '0, got);
        end else begin
          want = utf8_expected.pop_front();
          if (got !== want) report_mismatch("result mismatch", want, got);
        end
      end
    end
    pending_bytes = utf8_expected.size();
  end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Top of the converter testbench: clock, reset, code unit stimulus, output stalls and verdict.
module testbench;

  localparam int RANDOM_UNITS = 440;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;  // code_unit [15:0], char_limit [23:16]
  logic        s_tlast = 1'b0;
  logic [0:0]  s_tuser = '0;  // first_unit [0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;  // out_byte [7:0]
  logic        m_tlast;
  logic [1:0]  m_tuser;  // byte_valid [0], end_of_name [1]

  int mismatch_count;
  int pending_bytes;
  int burst_left = 0;
  int name_units = 0;
  int stall_mode = 0;
  int stall_phase = 0;

  utf16_to_utf8_converter uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  utf8_stream_checker checker_i (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .mismatch_count(mismatch_count),
    .pending_bytes(pending_bytes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver picks one of four stall patterns at random whenever the stall phase wraps.
  always @(negedge clk) begin
    if (stall_phase == 0) stall_mode <= $urandom_range(0, 3);
    stall_phase <= (stall_phase + 1) % 48;
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (stall_phase % 5 != 0);
    endcase
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // Entered and left at a falling edge; the request stays valid until the caller moves on.
  task automatic send_unit(input logic [15:0] unit, input logic first, input logic last,
                           input logic [7:0] limit);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {limit, unit};
    s_tlast <= last;
    s_tuser <= first;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  function automatic logic [15:0] random_unit();
    case ($urandom_range(0, 11))
      0, 1, 2: return 16'($urandom_range(1, 16'h7F));
      3, 4: return 16'($urandom_range(16'h80, 16'h7FF));
      5, 6: return 16'($urandom_range(16'h800, 16'hD7FF));
      7: return 16'($urandom_range(16'hE000, 16'hFFFF));
      8: return 16'($urandom_range(16'hDC00, 16'hDFFF));
      9: return 16'($urandom_range(16'hD800, 16'hDBFF));
      10: return 16'($urandom);
      default: return ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
    endcase
  endfunction

  task automatic send_name(input logic terminated);
    int          len;
    int          i;
    logic [7:0]  lim;
    len = $urandom_range(1, 12);
    case ($urandom_range(0, 9))
      0: lim = 8'd0;
      1: lim = 8'd255;
      2: lim = 8'($urandom_range(0, 255));
      default: lim = 8'($urandom_range(0, len + 2));
    endcase
    i = 0;
    while (i < len) begin
      if (i + 1 < len && $urandom_range(0, 4) == 0) begin
        send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), i == 0, 1'b0, lim);
        send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), 1'b0,
                  terminated && i + 2 == len, lim);
        i += 2;
      end else begin
        send_unit(random_unit(), i == 0, terminated && i + 1 == len, lim);
        i++;
      end
    end
    name_units += len;
  endtask

  initial begin
    int pick;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A unit before any name has started is ignored.
    send_unit(16'h0041, 1'b0, 1'b0, 8'd0);

    // One, two, three and four byte encodings, pairs, and lone surrogates.
    send_unit(16'h0041, 1'b1, 1'b0, 8'd255);
    send_unit(16'h007F, 1'b0, 1'b0, 8'd0);
    send_unit(16'h0080, 1'b0, 1'b0, 8'd0);
    send_unit(16'h07FF, 1'b0, 1'b0, 8'd0);
    send_unit(16'h0800, 1'b0, 1'b0, 8'd0);
    send_unit(16'hFFFF, 1'b0, 1'b0, 8'd0);
    send_unit(16'hD800, 1'b0, 1'b0, 8'd0);
    send_unit(16'hDC00, 1'b0, 1'b0, 8'd0);
    send_unit(16'hDBFF, 1'b0, 1'b0, 8'd0);
    send_unit(16'hDFFF, 1'b0, 1'b0, 8'd0);
    send_unit(16'hDC00, 1'b0, 1'b0, 8'd0);
    send_unit(16'hD801, 1'b0, 1'b0, 8'd0);
    send_unit(16'h0042, 1'b0, 1'b0, 8'd0);
    send_unit(16'hDBFF, 1'b0, 1'b1, 8'd0);

    // After a closed name, units are ignored but a last mark still closes again.
    send_unit(16'h0043, 1'b0, 1'b0, 8'd0);
    send_unit(16'h0044, 1'b0, 1'b1, 8'd0);

    // A low surrogate just past the limit still completes its pair.
    send_unit(16'h0043, 1'b1, 1'b0, 8'd2);
    send_unit(16'hD83D, 1'b0, 1'b0, 8'd0);
    send_unit(16'hDE00, 1'b0, 1'b0, 8'd0);
    send_unit(16'h0044, 1'b0, 1'b1, 8'd0);

    // A held high surrogate is dropped by a new name, and a zero unit stops conversion.
    send_unit(16'hD800, 1'b1, 1'b0, 8'd5);
    send_unit(16'h0045, 1'b1, 1'b0, 8'd5);
    send_unit(16'h0000, 1'b0, 1'b0, 8'd0);
    send_unit(16'h0046, 1'b0, 1'b1, 8'd0);

    // A whole name in one request.
    send_unit(16'h0047, 1'b1, 1'b1, 8'd0);

    while (name_units < RANDOM_UNITS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_name(1'b0);
      end else if (pick == 1) begin
        repeat ($urandom_range(1, 3))
          send_unit(random_unit(), 1'b0, 1'($urandom_range(0, 1)), 8'($urandom));
      end else begin
        send_name(1'b1);
      end
    end
    s_tvalid <= 1'b0;

    while (pending_bytes != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/u2u8_pkg.sv
hw/rtl/u2u8_front.sv
hw/rtl/u2u8_queue.sv
hw/rtl/u2u8_back.sv
hw/rtl/utf16_to_utf8_converter.sv
test/utf8_stream_checker.sv
test/testbench.sv
